/* rtl/core/srld_pkg.sv */
// Shared types and constants for the run-length sprite row decoder.
// Used by the top level, srld_decode and srld_emit; depends on nothing else.
package srld_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LEFT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TOP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_COLS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS = 3'd4;

    // Input item kinds.
    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_ROW     = 2'd1;
    localparam logic [1:0] KIND_BYTE    = 2'd2;

    // Encoded stream control byte fields.
    localparam int SKIP_BIT   = 7;
    localparam int REPEAT_BIT = 6;

    typedef enum logic [1:0] {
        MODE_CONTROL = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_LITERAL = 2'd2
    } srld_mode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] entry_colour;
        logic [7:0]  row_number;
    } srld_in_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [31:0] pixel_colour;
        logic        last;
    } srld_out_t;

    // One run of visible pixels handed from the decoder to the emitter.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [5:0]  count;
    } srld_job_t;

endpackage

/* rtl/core/sprite_rle_row_decoder.sv */
// Top level of the run-length sprite row decoder.
// Depends on srld_pkg, srld_palette, srld_decode and srld_emit.
//
// Input beats carry a palette write, a row start or one encoded row byte.
// Output beats carry one clipped pixel write each, with last set on the final
// pixel caused by an input beat. The user must use the config write port
// (cfg_write, cfg_index, cfg_data) only while the block is idle (unenforced).
//
// The first pixel of an encoded byte reaches the output through the palette
// read and run buffer, then the output register. Throughput: one input beat
// per cycle, while in_ready is high, for control bytes, palette writes, row
// starts and literal index bytes. A repeat colour byte with n visible
// pixels occupies the output register for n beats; the one-run buffer in
// front of it then fills and in_ready drops until the run drains.
// A receiver stall holds the current pixel and, once the run buffer is full,
// holds in_ready low. Reset clears the decoding state, the configuration
// registers and both valid flags; the palette is not cleared and must be
// written before use.
module sprite_rle_row_decoder #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  srld_pkg::srld_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output srld_pkg::srld_out_t              out_data,
    input  logic                             cfg_write,
    input  logic [srld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srld_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    logic                in_accept;
    logic                pal_write;
    logic                job_load;
    srld_pkg::srld_job_t job;
    logic [31:0]         colour;

    assign in_accept = in_valid && in_ready;

    srld_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_item   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pal_write (pal_write),
        .job_load  (job_load),
        .job       (job)
    );

    srld_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_write),
        .wr_addr (in_data.byte_value[ADDR_W-1:0]),
        .wr_data (in_data.entry_colour),
        .rd_en   (job_load),
        .rd_addr (in_data.byte_value[ADDR_W-1:0]),
        .rd_data (colour)
    );

    srld_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_load   (job_load),
        .job        (job),
        .colour     (colour),
        .take_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

/* rtl/core/srld_palette.sv */
// Palette memory: one write port and one registered read port.
// Depends on nothing but its parameters.
module srld_palette #(
    parameter int ENTRIES = 256
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  logic [31:0]                wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic [31:0]                rd_data
);

    logic [31:0] mem [ENTRIES];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/srld_decode.sv */
// Configuration registers and row decoding state; turns each accepted beat
// into state updates and, where pixels are visible, one run for the emitter.
// Depends on srld_pkg.
module srld_decode (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_accept,
    input  srld_pkg::srld_in_t                  in_item,
    input  logic                                cfg_write,
    input  logic [srld_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srld_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                pal_write,
    output logic                                job_load,
    output srld_pkg::srld_job_t                 job
);

    logic [7:0]  frame_left_reg;
    logic [7:0]  frame_top_reg;
    logic [7:0]  frame_cols_reg;
    logic [15:0] image_cols_reg;
    logic [15:0] image_rows_reg;

    srld_pkg::srld_mode_t mode_reg, mode_next;
    logic [5:0] run_reg, run_next;
    logic [9:0] col_reg, col_next;
    logic [8:0] row_reg, row_next;
    logic       live_reg, live_next;

    logic        is_row;
    logic        is_byte;
    logic        row_open;
    logic [15:0] img_room;
    logic [7:0]  limit;
    logic [10:0] run_end;
    logic [10:0] vis_end;
    logic [10:0] vis_diff;
    logic [5:0]  rep_count;
    logic        lit_vis;
    logic [8:0]  dy;
    logic [7:0]  b;

    assign b        = in_item.byte_value;
    assign is_row   = in_accept && (in_item.kind == srld_pkg::KIND_ROW);
    assign is_byte  = in_accept && (in_item.kind == srld_pkg::KIND_BYTE) && live_reg;
    assign row_open = col_reg < {2'd0, frame_cols_reg};
    assign pal_write = in_accept && (in_item.kind == srld_pkg::KIND_PALETTE);

    // The visible part of a row is the columns below the smaller of the frame
    // width and the room left in the image to the right of the frame edge.
    assign img_room = (image_cols_reg > {8'd0, frame_left_reg})
                    ? image_cols_reg - {8'd0, frame_left_reg} : 16'd0;
    assign limit    = (img_room < {8'd0, frame_cols_reg}) ? img_room[7:0] : frame_cols_reg;
    assign run_end  = {1'b0, col_reg} + {5'd0, run_reg};
    assign vis_end  = (run_end < {3'd0, limit}) ? run_end : {3'd0, limit};
    assign vis_diff = vis_end - {1'b0, col_reg};
    assign rep_count = (vis_end > {1'b0, col_reg}) ? vis_diff[5:0] : 6'd0;
    assign lit_vis  = col_reg < {2'd0, limit};
    assign dy       = {1'b0, frame_top_reg} + {1'b0, in_item.row_number};

    assign job.x     = {8'd0, frame_left_reg} + {6'd0, col_reg};
    assign job.y     = {7'd0, row_reg};
    assign job.count = (mode_reg == srld_pkg::MODE_REPEAT) ? rep_count : 6'd1;
    assign job_load  = is_byte
                    && (((mode_reg == srld_pkg::MODE_REPEAT) && (rep_count != 6'd0))
                    || ((mode_reg == srld_pkg::MODE_LITERAL) && lit_vis));

    // Decode mode transitions.
    always_comb
    begin
        mode_next = mode_reg;
        if (is_row)
        begin
            mode_next = srld_pkg::MODE_CONTROL;
        end
        else if (is_byte)
        begin
            case (mode_reg)
                srld_pkg::MODE_REPEAT:
                begin
                    mode_next = srld_pkg::MODE_CONTROL;
                end
                srld_pkg::MODE_LITERAL:
                begin
                    if (run_reg == 6'd1)
                    begin
                        mode_next = srld_pkg::MODE_CONTROL;
                    end
                end
                srld_pkg::MODE_CONTROL:
                begin
                    if (row_open && !b[srld_pkg::SKIP_BIT])
                    begin
                        if (b[srld_pkg::REPEAT_BIT])
                        begin
                            mode_next = srld_pkg::MODE_REPEAT;
                        end
                        else if (b[5:0] != 6'd0)
                        begin
                            mode_next = srld_pkg::MODE_LITERAL;
                        end
                    end
                end
                default:
                begin
                    mode_next = srld_pkg::MODE_CONTROL;
                end
            endcase
        end
    end

    // Column, run and row bookkeeping.
    always_comb
    begin
        run_next  = run_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        live_next = live_reg;
        if (is_row)
        begin
            row_next  = dy;
            live_next = {7'd0, dy} < image_rows_reg;
            col_next  = 10'd0;
            run_next  = 6'd0;
        end
        else if (is_byte)
        begin
            case (mode_reg)
                srld_pkg::MODE_REPEAT:
                begin
                    col_next = col_reg + {4'd0, run_reg};
                    run_next = 6'd0;
                end
                srld_pkg::MODE_LITERAL:
                begin
                    col_next = col_reg + 10'd1;
                    run_next = run_reg - 6'd1;
                end
                srld_pkg::MODE_CONTROL:
                begin
                    if (row_open)
                    begin
                        if (b[srld_pkg::SKIP_BIT])
                        begin
                            col_next = col_reg + {3'd0, b[6:0]};
                        end
                        else
                        begin
                            run_next = b[5:0];
                        end
                    end
                end
                default:
                begin
                    run_next = run_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= srld_pkg::MODE_CONTROL;
            run_reg  <= 6'd0;
            col_reg  <= 10'd0;
            row_reg  <= 9'd0;
            live_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            run_reg  <= run_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_left_reg <= 8'd0;
            frame_top_reg  <= 8'd0;
            frame_cols_reg <= 8'd0;
            image_cols_reg <= 16'd0;
            image_rows_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                srld_pkg::REG_FRAME_LEFT: frame_left_reg <= cfg_data[7:0];
                srld_pkg::REG_FRAME_TOP:  frame_top_reg  <= cfg_data[7:0];
                srld_pkg::REG_FRAME_COLS: frame_cols_reg <= cfg_data[7:0];
                srld_pkg::REG_IMAGE_COLS: image_cols_reg <= cfg_data;
                srld_pkg::REG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                default:                  frame_left_reg <= frame_left_reg;
            endcase
        end
    end

    // A run is only ever open inside a live row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != srld_pkg::MODE_CONTROL) |-> live_reg)
        else $error("decode mode left control outside a live row");

    // A literal run always has index bytes still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == srld_pkg::MODE_LITERAL) |-> (run_reg != 6'd0))
        else $error("literal mode with an empty run");

endmodule

/* rtl/core/srld_emit.sv */
// Run buffer and output register: holds one pending run and steps the
// current run out one pixel per beat. Depends on srld_pkg.
module srld_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_load,
    input  srld_pkg::srld_job_t  job,
    input  logic [31:0]          colour,
    output logic                 take_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srld_pkg::srld_out_t  out_data
);

    logic                job_valid_reg, job_valid_next;
    srld_pkg::srld_job_t job_reg;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_x_reg;
    logic [15:0]         out_y_reg;
    logic [31:0]         out_colour_reg;
    logic [5:0]          out_left_reg;
    logic                out_step;
    logic                out_free;
    logic                job_moves;

    assign out_step   = out_valid_reg && out_ready && (out_left_reg != 6'd1);
    assign out_free   = !out_valid_reg || (out_ready && (out_left_reg == 6'd1));
    assign job_moves  = job_valid_reg && out_free;
    assign take_ready = !job_valid_reg || job_moves;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (job_load)
        begin
            job_valid_next = 1'b1;
        end
        else if (job_moves)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = job_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The palette word for the pending run arrives the cycle after its load,
    // which is exactly when that run can first move into the output register.
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
        if (out_step)
        begin
            out_x_reg    <= out_x_reg + 16'd1;
            out_left_reg <= out_left_reg - 6'd1;
        end
        else if (job_moves)
        begin
            out_x_reg      <= job_reg.x;
            out_y_reg      <= job_reg.y;
            out_colour_reg <= colour;
            out_left_reg   <= job_reg.count;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data.pixel_x      = out_x_reg;
    assign out_data.pixel_y      = out_y_reg;
    assign out_data.pixel_colour = out_colour_reg;
    assign out_data.last         = (out_left_reg == 6'd1);

    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_reg.count != 6'd0))
        else $error("empty run held in the run buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_left_reg != 6'd0))
        else $error("output register valid with no pixels left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && (out_left_reg != 6'd1))
        |=> (out_valid_reg && (out_x_reg == $past(out_x_reg) + 16'd1)
             && (out_colour_reg == $past(out_colour_reg))))
        else $error("run did not advance by one column");

endmodule
